// ----- hw/rtl/pms_pkg.sv -----
// Shared types, codes and constants of the position move supervisor.
`timescale 1ns / 1ps

package pms_pkg;

    // Width of the shared add/subtract unit: covers 33-bit errors plus margin with sign.
    localparam int ALU_W = 35;

    localparam int MOTOR_W  = 8;
    localparam int FIELD_W  = 32;
    localparam int SPEED_W  = 16;
    localparam int LIMIT_W  = 31;
    localparam int MSPEED_W = 15;
    localparam int TIME_W   = 16;

    // Input tdata layout, lowest bit first.
    localparam int IN_MOTOR_LSB  = 0;
    localparam int IN_TARGET_LSB = 8;
    localparam int IN_TOL_LSB    = 40;
    localparam int IN_SPEED_LSB  = 72;
    localparam int IN_POS_LSB    = 88;
    localparam int IN_NOW_LSB    = 120;
    localparam int IN_DATA_W     = 152;

    localparam int OUT_FIELDS_W = 26;
    localparam int OUT_DATA_W   = 32;

    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_STOP   = 3'd1,
        OP_UPDATE = 3'd2,
        OP_SPEED  = 3'd3,
        OP_RESET  = 3'd4
    } op_t;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_DRIVE = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;
    localparam logic [1:0] ACT_RESET = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_IGNORED = 3'd1;
    localparam logic [2:0] ST_HOLD    = 3'd2;
    localparam logic [2:0] ST_LIMIT   = 3'd3;
    localparam logic [2:0] ST_ABORT   = 3'd4;
    localparam logic [2:0] ST_IDLE    = 3'd5;

    localparam logic [2:0] CFG_ODD_MAX  = 3'd0;
    localparam logic [2:0] CFG_EVEN_MAX = 3'd1;
    localparam logic [2:0] CFG_MSPEED   = 3'd2;
    localparam logic [2:0] CFG_TIMEOUT  = 3'd3;
    localparam logic [2:0] CFG_MARGIN   = 3'd4;

    localparam logic [LIMIT_W-1:0]  RST_ODD_MAX  = 31'd3000;
    localparam logic [LIMIT_W-1:0]  RST_EVEN_MAX = 31'd3500;
    localparam logic [MSPEED_W-1:0] RST_MSPEED   = 15'd170;
    localparam logic [TIME_W-1:0]   RST_TIMEOUT  = 16'd150;
    localparam logic [TIME_W-1:0]   RST_MARGIN   = 16'd10;

    localparam logic [FIELD_W-1:0] BEST_INIT = 32'h7fff_ffff;

    // One result beat before packing.
    typedef struct packed {
        logic        limits_on;
        logic        move_active;
        logic [2:0]  status;
        logic [15:0] drive_speed;
        logic [1:0]  action;
        logic [2:0]  motor_out;
    } result_t;

endpackage

// ----- hw/rtl/pms_alu.sv -----
// Shared add/subtract unit used by every arithmetic step of the sequencer.
`timescale 1ns / 1ps

module pms_alu (
    input  logic signed [pms_pkg::ALU_W-1:0] a,
    input  logic signed [pms_pkg::ALU_W-1:0] b,
    input  logic                             sub,
    output logic signed [pms_pkg::ALU_W-1:0] y
);

    logic [pms_pkg::ALU_W-1:0] b_eff;

    always_comb begin
        b_eff = sub ? ~b : b;
        y     = a + $signed(b_eff) + $signed({{(pms_pkg::ALU_W-1){1'b0}}, sub});
    end

endmodule

// ----- hw/rtl/position_move_supervisor.sv -----
// Top level of the position move supervisor: sequencer, motor state and ports.
`timescale 1ns / 1ps
// Stop, reset encoder and ignored items go from capture straight to the final step; start move
// and set speed pass the limit step first; an update walks eight steps through the
// single shared add/subtract unit. The final step waits while the output register is full
// and not taken. The input is not ready while an item is in work.
// Reset (aresetn low, synchronous) clears all moves, turns travel limits off, loads the
// register defaults and empties the output register.

module position_move_supervisor #(
    parameter int NUM_MOTORS = 4,
    parameter int POS_WIDTH  = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: motor_id[7:0], target[39:8], tolerance[71:40], speed[87:72],
    //        position[119:88], now_ms[151:120]
    input  logic [pms_pkg::IN_DATA_W-1:0]     s_tdata,
    // tuser: operation[2:0]
    input  logic [2:0]                        s_tuser,
    // Result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: motor_out[2:0], action[4:3], drive_speed[20:5], status[23:21],
    //        move_active[24], limits_on[25], zero fill[31:26]
    output logic [pms_pkg::OUT_DATA_W-1:0]    m_tdata,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [31:0]                       cfg_data
);

    localparam int IW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int AW = pms_pkg::ALU_W;

    // Sequencer steps; an update visits all of them in order.
    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_ABS, S_BAND, S_LIM, S_MADD, S_PCMP, S_TSUB, S_TCMP, S_FIN
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [pms_pkg::LIMIT_W-1:0]  odd_max_reg, even_max_reg;
    logic [pms_pkg::MSPEED_W-1:0] mspeed_reg;
    logic [pms_pkg::TIME_W-1:0]   timeout_reg, margin_reg;

    // Per-motor move state
    logic                          move_on_reg [NUM_MOTORS];
    logic signed [POS_WIDTH-1:0]   goal_reg    [NUM_MOTORS];
    logic [pms_pkg::LIMIT_W-1:0]   band_reg    [NUM_MOTORS];
    logic [pms_pkg::FIELD_W-1:0]   best_reg    [NUM_MOTORS];
    logic                          nobest_reg  [NUM_MOTORS];
    logic [pms_pkg::FIELD_W-1:0]   stamp_reg   [NUM_MOTORS];
    logic                          limits_reg;

    // Item under work
    pms_pkg::op_t                  op_reg;
    logic [pms_pkg::MOTOR_W-1:0]   motor_reg;
    logic                          valid_reg;
    logic [IW-1:0]                 idx_reg;
    logic signed [POS_WIDTH-1:0]   target_reg, pos_reg;
    logic signed [31:0]            tol_reg;
    logic signed [15:0]            speed_reg;
    logic [31:0]                   now_reg;

    // Step results
    logic signed [32:0]            err_reg;
    logic [32:0]                   aerr_reg;
    logic [33:0]                   sum_reg;
    logic [31:0]                   elapsed_reg;
    logic                          in_band_reg, ge_reg, gt_reg, less_reg, tout_reg;

    // Output register
    logic                          m_tvalid_reg;
    pms_pkg::result_t              out_reg;

    // Input decode
    logic [pms_pkg::MOTOR_W-1:0]   in_motor;
    logic                          in_valid;
    pms_pkg::op_t                  in_op;
    logic                          accept;

    assign in_motor = s_tdata[pms_pkg::IN_MOTOR_LSB +: pms_pkg::MOTOR_W];
    assign in_valid = (in_motor != '0) && (in_motor <= pms_pkg::MOTOR_W'(NUM_MOTORS));
    assign in_op    = pms_pkg::op_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Current motor entry and its upper travel limit
    logic                          cur_move, cur_nobest;
    logic signed [POS_WIDTH-1:0]   cur_goal;
    logic [pms_pkg::LIMIT_W-1:0]   cur_band, hi;
    logic [31:0]                   cur_best, cur_stamp;

    always_comb begin
        cur_move   = move_on_reg[idx_reg];
        cur_goal   = goal_reg[idx_reg];
        cur_band   = band_reg[idx_reg];
        cur_best   = best_reg[idx_reg];
        cur_nobest = nobest_reg[idx_reg];
        cur_stamp  = stamp_reg[idx_reg];
        hi         = motor_reg[0] ? odd_max_reg : even_max_reg;
    end

    // Shared unit operand select
    logic signed [AW-1:0] alu_a, alu_b, alu_y;
    logic                 alu_sub;

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (state_reg)
            S_ERR: begin
                alu_a = {{(AW-POS_WIDTH){cur_goal[POS_WIDTH-1]}}, cur_goal};
                alu_b = {{(AW-POS_WIDTH){pos_reg[POS_WIDTH-1]}}, pos_reg};
            end
            S_ABS: begin
                alu_b = {{(AW-33){err_reg[32]}}, err_reg};
            end
            S_BAND: begin
                alu_a = {{(AW-pms_pkg::LIMIT_W){1'b0}}, cur_band};
                alu_b = {{(AW-33){1'b0}}, aerr_reg};
            end
            S_LIM: begin
                alu_a = (op_reg == pms_pkg::OP_START)
                      ? {{(AW-POS_WIDTH){target_reg[POS_WIDTH-1]}}, target_reg}
                      : {{(AW-POS_WIDTH){pos_reg[POS_WIDTH-1]}}, pos_reg};
                alu_b = {{(AW-pms_pkg::LIMIT_W){1'b0}}, hi};
            end
            S_MADD: begin
                alu_a   = {{(AW-33){1'b0}}, aerr_reg};
                alu_b   = {{(AW-pms_pkg::TIME_W){1'b0}}, margin_reg};
                alu_sub = 1'b0;
            end
            S_PCMP: begin
                alu_a = {{(AW-34){1'b0}}, sum_reg};
                alu_b = {{(AW-32){1'b0}}, cur_best};
            end
            S_TSUB: begin
                alu_a = {{(AW-32){1'b0}}, now_reg};
                alu_b = {{(AW-32){1'b0}}, cur_stamp};
            end
            S_TCMP: begin
                alu_a = {{(AW-32){1'b0}}, elapsed_reg};
                alu_b = {{(AW-pms_pkg::TIME_W){1'b0}}, timeout_reg};
            end
            default: begin
                alu_sub = 1'b1;
            end
        endcase
    end

    pms_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y)
    );

    // Final decision of one item: result beat and state writes
    pms_pkg::result_t              res;
    logic                          clr_all, clr_one, start_wr, prog_wr, lim_set;
    logic signed [POS_WIDTH-1:0]   new_goal;
    logic [31:0]                   stored_err;
    logic                          err_pos, pos_le0, toward;
    logic [15:0]                   move_drive;

    always_comb begin
        res        = '0;
        res.status = pms_pkg::ST_IGNORED;
        res.action = pms_pkg::ACT_NONE;
        clr_all    = 1'b0;
        clr_one    = 1'b0;
        start_wr   = 1'b0;
        prog_wr    = 1'b0;
        lim_set    = 1'b0;
        toward     = 1'b0;
        new_goal   = target_reg;
        stored_err = aerr_reg[32] ? 32'hffff_ffff : aerr_reg[31:0];
        err_pos    = !err_reg[32] && (err_reg != '0);
        pos_le0    = pos_reg[POS_WIDTH-1] || (pos_reg == '0);
        move_drive = err_pos ? -{1'b0, mspeed_reg} : {1'b0, mspeed_reg};

        if (limits_reg && gt_reg) begin
            new_goal = POS_WIDTH'(hi);
        end else if (limits_reg && target_reg[POS_WIDTH-1]) begin
            new_goal = '0;
        end

        case (op_reg)
            pms_pkg::OP_START: begin
                if (valid_reg && !tol_reg[31]) begin
                    start_wr        = 1'b1;
                    res.motor_out   = motor_reg[2:0];
                    res.status      = pms_pkg::ST_OK;
                    res.move_active = 1'b1;
                end
            end
            pms_pkg::OP_STOP, pms_pkg::OP_RESET: begin
                if (motor_reg == '0 || valid_reg) begin
                    clr_all       = (motor_reg == '0);
                    clr_one       = (motor_reg != '0);
                    lim_set       = (op_reg == pms_pkg::OP_RESET);
                    res.motor_out = motor_reg[2:0];
                    res.action    = (op_reg == pms_pkg::OP_RESET) ? pms_pkg::ACT_RESET
                                                                   : pms_pkg::ACT_STOP;
                    res.status    = pms_pkg::ST_OK;
                end
            end
            pms_pkg::OP_SPEED: begin
                if (valid_reg) begin
                    clr_one       = 1'b1;
                    res.motor_out = motor_reg[2:0];
                    toward = limits_reg &&
                             ((!speed_reg[15] && speed_reg != '0 && ge_reg) ||
                              (speed_reg[15] && pos_le0));
                    if (toward) begin
                        res.action = pms_pkg::ACT_STOP;
                        res.status = pms_pkg::ST_LIMIT;
                    end else begin
                        // Inverted mounting; the most negative speed saturates
                        res.drive_speed = (speed_reg == 16'sh8000) ? 16'h7fff : -speed_reg;
                        res.action      = pms_pkg::ACT_DRIVE;
                        res.status      = pms_pkg::ST_OK;
                    end
                end
            end
            pms_pkg::OP_UPDATE: begin
                if (valid_reg) begin
                    res.motor_out = motor_reg[2:0];
                    toward = limits_reg && ((err_pos && ge_reg) || (!err_pos && pos_le0));
                    if (!cur_move) begin
                        res.status = pms_pkg::ST_IDLE;
                    end else if (in_band_reg) begin
                        prog_wr         = 1'b1;
                        res.action      = pms_pkg::ACT_STOP;
                        res.status      = pms_pkg::ST_HOLD;
                        res.move_active = 1'b1;
                    end else if (toward) begin
                        clr_one    = 1'b1;
                        res.action = pms_pkg::ACT_STOP;
                        res.status = pms_pkg::ST_LIMIT;
                    end else if (cur_nobest || less_reg) begin
                        prog_wr         = 1'b1;
                        res.drive_speed = move_drive;
                        res.action      = pms_pkg::ACT_DRIVE;
                        res.status      = pms_pkg::ST_OK;
                        res.move_active = 1'b1;
                    end else if (tout_reg) begin
                        clr_one    = 1'b1;
                        res.action = pms_pkg::ACT_STOP;
                        res.status = pms_pkg::ST_ABORT;
                    end else begin
                        res.drive_speed = move_drive;
                        res.action      = pms_pkg::ACT_DRIVE;
                        res.status      = pms_pkg::ST_OK;
                        res.move_active = 1'b1;
                    end
                end
            end
            default: begin
                res.status = pms_pkg::ST_IGNORED;
            end
        endcase
        res.limits_on = limits_reg || lim_set;
    end

    logic fin_go;
    assign fin_go = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);

    // Next step of the sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_valid && in_op == pms_pkg::OP_UPDATE) begin
                        state_next = S_ERR;
                    end else if (in_valid && (in_op == pms_pkg::OP_SPEED ||
                               (in_op == pms_pkg::OP_START &&
                                !s_tdata[pms_pkg::IN_TOL_LSB + 31]))) begin
                        state_next = S_LIM;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_ERR:  state_next = S_ABS;
            S_ABS:  state_next = S_BAND;
            S_BAND: state_next = S_LIM;
            S_LIM:  state_next = (op_reg == pms_pkg::OP_UPDATE) ? S_MADD : S_FIN;
            S_MADD: state_next = S_PCMP;
            S_PCMP: state_next = S_TSUB;
            S_TSUB: state_next = S_TCMP;
            S_TCMP: state_next = S_FIN;
            S_FIN: begin
                if (fin_go) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer, item capture, step results and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fin_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end

        if (accept) begin
            op_reg     <= in_op;
            motor_reg  <= in_motor;
            valid_reg  <= in_valid;
            idx_reg    <= IW'(in_motor - 8'd1);
            target_reg <= s_tdata[pms_pkg::IN_TARGET_LSB +: POS_WIDTH];
            tol_reg    <= s_tdata[pms_pkg::IN_TOL_LSB +: 32];
            speed_reg  <= s_tdata[pms_pkg::IN_SPEED_LSB +: 16];
            pos_reg    <= s_tdata[pms_pkg::IN_POS_LSB +: POS_WIDTH];
            now_reg    <= s_tdata[pms_pkg::IN_NOW_LSB +: 32];
        end

        case (state_reg)
            S_ERR:  err_reg     <= alu_y[32:0];
            S_ABS:  aerr_reg    <= err_reg[32] ? alu_y[32:0] : err_reg;
            S_BAND: in_band_reg <= !alu_y[AW-1];
            S_LIM: begin
                ge_reg <= !alu_y[AW-1];
                gt_reg <= !alu_y[AW-1] && (alu_y != '0);
            end
            S_MADD: sum_reg     <= alu_y[33:0];
            S_PCMP: less_reg    <= alu_y[AW-1];
            S_TSUB: elapsed_reg <= alu_y[31:0];
            S_TCMP: tout_reg    <= !alu_y[AW-1];
            default: begin
            end
        endcase

        if (fin_go) begin
            out_reg <= res;
        end
    end

    // Configuration registers and motor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            odd_max_reg  <= pms_pkg::RST_ODD_MAX;
            even_max_reg <= pms_pkg::RST_EVEN_MAX;
            mspeed_reg   <= pms_pkg::RST_MSPEED;
            timeout_reg  <= pms_pkg::RST_TIMEOUT;
            margin_reg   <= pms_pkg::RST_MARGIN;
            limits_reg   <= 1'b0;
            for (int i = 0; i < NUM_MOTORS; i++) begin
                move_on_reg[i] <= 1'b0;
                goal_reg[i]    <= '0;
                band_reg[i]    <= '0;
                best_reg[i]    <= '0;
                nobest_reg[i]  <= 1'b0;
                stamp_reg[i]   <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pms_pkg::CFG_ODD_MAX:  odd_max_reg  <= cfg_data[30:0];
                    pms_pkg::CFG_EVEN_MAX: even_max_reg <= cfg_data[30:0];
                    pms_pkg::CFG_MSPEED:   mspeed_reg   <= cfg_data[14:0];
                    pms_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_data[15:0];
                    pms_pkg::CFG_MARGIN:   margin_reg   <= cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            if (fin_go && lim_set) begin
                limits_reg <= 1'b1;
            end
            for (int i = 0; i < NUM_MOTORS; i++) begin
                if (fin_go && (clr_all || (clr_one && idx_reg == IW'(i)))) begin
                    move_on_reg[i] <= 1'b0;
                    goal_reg[i]    <= '0;
                    band_reg[i]    <= '0;
                    best_reg[i]    <= '0;
                    nobest_reg[i]  <= 1'b0;
                    stamp_reg[i]   <= '0;
                end else if (fin_go && start_wr && idx_reg == IW'(i)) begin
                    move_on_reg[i] <= 1'b1;
                    goal_reg[i]    <= new_goal;
                    band_reg[i]    <= tol_reg[30:0];
                    best_reg[i]    <= pms_pkg::BEST_INIT;
                    nobest_reg[i]  <= 1'b1;
                    stamp_reg[i]   <= now_reg;
                end else if (fin_go && prog_wr && idx_reg == IW'(i)) begin
                    best_reg[i]    <= stored_err;
                    nobest_reg[i]  <= 1'b0;
                    stamp_reg[i]   <= now_reg;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(pms_pkg::OUT_DATA_W-pms_pkg::OUT_FIELDS_W){1'b0}}, out_reg};

    // A result beat only appears after the final step of an item
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_FIN))
        else $error("result beat without a finished item");

    // One item at a time: the input closes right after a beat is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still open after accepting an item");

    // Drive value is zero unless the action is a drive
    a_drive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:3] != pms_pkg::ACT_DRIVE) |-> (m_tdata[20:5] == '0))
        else $error("drive value on a non-drive result");

    // Ignored items name no motor and take no action
    a_ignored_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[23:21] == pms_pkg::ST_IGNORED) |->
            (m_tdata[2:0] == '0) && (m_tdata[4:3] == pms_pkg::ACT_NONE) && !m_tdata[24])
        else $error("ignored item produced an action");

endmodule
